/* rtl/oag_pkg.sv */
// ----------------------------------------------------------------------------
// oag_pkg
// Shared types, constants and helpers of the yuv 4:2:0 overlay address
// generator.
// ----------------------------------------------------------------------------
package oag_pkg;

    localparam int ADDR_W      = 25;
    localparam int DATA_W      = 8;
    localparam int CFG_SIZE_W  = 13;
    localparam int POS_W       = 14;
    localparam int SIZE_W      = 14;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_DEST_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_X       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_Y       = 3'd5;

    localparam logic [CFG_SIZE_W-1:0] DEST_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_SIZE_W-1:0] DEST_HEIGHT_RST = 13'd1080;
    localparam logic [CFG_SIZE_W-1:0] SRC_WIDTH_RST   = 13'd320;
    localparam logic [CFG_SIZE_W-1:0] SRC_HEIGHT_RST  = 13'd240;

    typedef enum logic [1:0] {
        PLANE_Y,
        PLANE_CB,
        PLANE_CR,
        PLANE_DONE
    } plane_t;

    typedef struct packed {
        logic [SIZE_W-1:0] dest_width;
        logic [SIZE_W-1:0] dest_height;
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } geom_cfg_t;

    typedef struct packed {
        logic              wr;
        logic              rej;
        plane_t            plane;
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] row_base;
        logic [ADDR_W-1:0] luma_size;
        logic [ADDR_W-1:0] col_offset;
    } addr_op_t;

    // saturate to [2, maxv] and round down to even
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] t;
        t = {1'b0, v};
        if (t < 14'd2)
        begin
            t = 14'd2;
        end
        if (t > maxv)
        begin
            t = maxv;
        end
        t[0] = 1'b0;
        return t;
    endfunction

endpackage

/* rtl/yuv420_overlay_address_gen.sv */
// ----------------------------------------------------------------------------
// yuv420_overlay_address_gen
// Write address generator for pasting a planar yuv 4:2:0 overlay frame into a
// larger destination frame buffer, clipped at the right and bottom edges.
//
// Input channel: in_valid / in_stall carry one source byte per beat in storage
// order (y plane, then cb, then cr); frame_start marks the first byte of a
// frame and restarts the counters before that byte is placed.
// Output channel: out_valid / out_stall carry one result per input beat:
// write_enable, dest_address, write_data and rejected.
// Configuration: cfg_we writes cfg_data into register cfg_index (dest width,
// dest height, src width, src height, pos x, pos y); unknown indexes are
// ignored. Write only while the pipeline is empty.
// Each accepted byte passes through a three stage pipeline (position
// counters, clip check and row multiply, address sum), one byte per cycle
// while out_stall is low.
// Reset clears the counters and the pipeline and loads the default geometry.
// While out_stall is high the pipeline fills, then in_stall rises.
// ----------------------------------------------------------------------------
module yuv420_overlay_address_gen #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [oag_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [oag_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                frame_start,
    input  logic [oag_pkg::DATA_W-1:0]          source_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_enable,
    output logic [oag_pkg::ADDR_W-1:0]          dest_address,
    output logic [oag_pkg::DATA_W-1:0]          write_data,
    output logic                                rejected
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [oag_pkg::CFG_SIZE_W-1:0] dest_width_reg, dest_height_reg;
    logic [oag_pkg::CFG_SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [oag_pkg::POS_W-1:0]      pos_x_reg, pos_y_reg;
    oag_pkg::geom_cfg_t             cfg;

    logic                adv1, adv2, adv3, accept;
    logic                v1, v2, v3;
    oag_pkg::plane_t     s1_plane;
    logic [RW-1:0]       s1_row;
    logic [CW-1:0]       s1_col;
    logic [oag_pkg::DATA_W-1:0] s1_data;
    oag_pkg::addr_op_t   s2_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= oag_pkg::DEST_WIDTH_RST;
            dest_height_reg <= oag_pkg::DEST_HEIGHT_RST;
            src_width_reg   <= oag_pkg::SRC_WIDTH_RST;
            src_height_reg  <= oag_pkg::SRC_HEIGHT_RST;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                oag_pkg::REG_DEST_WIDTH:  dest_width_reg  <= cfg_data[oag_pkg::CFG_SIZE_W-1:0];
                oag_pkg::REG_DEST_HEIGHT: dest_height_reg <= cfg_data[oag_pkg::CFG_SIZE_W-1:0];
                oag_pkg::REG_SRC_WIDTH:   src_width_reg   <= cfg_data[oag_pkg::CFG_SIZE_W-1:0];
                oag_pkg::REG_SRC_HEIGHT:  src_height_reg  <= cfg_data[oag_pkg::CFG_SIZE_W-1:0];
                oag_pkg::REG_POS_X:       pos_x_reg       <= cfg_data[oag_pkg::POS_W-1:0];
                oag_pkg::REG_POS_Y:       pos_y_reg       <= cfg_data[oag_pkg::POS_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        cfg.dest_width  = oag_pkg::eff_size(dest_width_reg,
                                            oag_pkg::SIZE_W'(MAX_WIDTH));
        cfg.dest_height = oag_pkg::eff_size(dest_height_reg,
                                            oag_pkg::SIZE_W'(MAX_HEIGHT));
        cfg.src_width   = oag_pkg::eff_size(src_width_reg,
                                            oag_pkg::SIZE_W'(MAX_WIDTH));
        cfg.src_height  = oag_pkg::eff_size(src_height_reg,
                                            oag_pkg::SIZE_W'(MAX_HEIGHT));
        cfg.pos_x       = pos_x_reg;
        cfg.pos_y       = pos_y_reg;
    end

    // each stage moves when it is empty or the next one moves
    assign adv3     = !v3 || !out_stall;
    assign adv2     = !v2 || adv3;
    assign adv1     = !v1 || adv2;
    assign in_stall = !adv1;
    assign accept   = in_valid && adv1;

    oag_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .load        (adv1),
        .in_valid    (in_valid),
        .frame_start (frame_start),
        .source_byte (source_byte),
        .src_width   (cfg.src_width),
        .src_height  (cfg.src_height),
        .valid       (v1),
        .plane       (s1_plane),
        .row         (s1_row),
        .col         (s1_col),
        .data        (s1_data)
    );

    oag_geometry #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geometry (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv2),
        .in_valid (v1),
        .cfg      (cfg),
        .plane    (s1_plane),
        .row      (s1_row),
        .col      (s1_col),
        .data     (s1_data),
        .valid    (v2),
        .op       (s2_op)
    );

    oag_address u_address (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (adv3),
        .in_valid     (v2),
        .op           (s2_op),
        .valid        (v3),
        .write_enable (write_enable),
        .dest_address (dest_address),
        .write_data   (write_data),
        .rejected     (rejected)
    );

    assign out_valid = v3;

endmodule

/* rtl/oag_position.sv */
// ----------------------------------------------------------------------------
// oag_position
// Source position tracking: plane, row and column counters advanced once per
// accepted beat, and the first pipeline register holding the byte's position.
// ----------------------------------------------------------------------------
module oag_position #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                load,
    input  logic                                in_valid,
    input  logic                                frame_start,
    input  logic [oag_pkg::DATA_W-1:0]          source_byte,
    input  logic [oag_pkg::SIZE_W-1:0]          src_width,
    input  logic [oag_pkg::SIZE_W-1:0]          src_height,
    output logic                                valid,
    output oag_pkg::plane_t                     plane,
    output logic [$clog2(MAX_HEIGHT)-1:0]       row,
    output logic [$clog2(MAX_WIDTH)-1:0]        col,
    output logic [oag_pkg::DATA_W-1:0]          data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    oag_pkg::plane_t         plane_reg, plane_next;
    logic [RW-1:0]           row_reg, row_next;
    logic [CW-1:0]           col_reg, col_next;

    oag_pkg::plane_t         cur_plane;
    logic [RW-1:0]           cur_row;
    logic [CW-1:0]           cur_col;
    logic [oag_pkg::SIZE_W-1:0] pw, ph, col_inc, row_inc;

    logic                    valid_reg;
    oag_pkg::plane_t         item_plane_reg;
    logic [RW-1:0]           item_row_reg;
    logic [CW-1:0]           item_col_reg;
    logic [oag_pkg::DATA_W-1:0] item_data_reg;

    always_comb
    begin
        cur_plane = frame_start ? oag_pkg::PLANE_Y : plane_reg;
        cur_row   = frame_start ? '0 : row_reg;
        cur_col   = frame_start ? '0 : col_reg;
        pw        = (cur_plane == oag_pkg::PLANE_Y) ? src_width  : (src_width  >> 1);
        ph        = (cur_plane == oag_pkg::PLANE_Y) ? src_height : (src_height >> 1);
        col_inc   = oag_pkg::SIZE_W'(cur_col) + 14'd1;
        row_inc   = oag_pkg::SIZE_W'(cur_row) + 14'd1;
        plane_next = cur_plane;
        row_next   = cur_row;
        col_next   = cur_col;
        if (cur_plane != oag_pkg::PLANE_DONE)
        begin
            if (col_inc >= pw)
            begin
                col_next = '0;
                if (row_inc >= ph)
                begin
                    row_next   = '0;
                    plane_next = oag_pkg::plane_t'(cur_plane + 2'd1);
                end
                else
                begin
                    row_next = row_inc[RW-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= oag_pkg::PLANE_Y;
            row_reg   <= '0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                plane_reg <= plane_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
            end
            if (load)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_plane_reg <= cur_plane;
            item_row_reg   <= cur_row;
            item_col_reg   <= cur_col;
            item_data_reg  <= source_byte;
        end
    end

    assign valid = valid_reg;
    assign plane = item_plane_reg;
    assign row   = item_row_reg;
    assign col   = item_col_reg;
    assign data  = item_data_reg;

endmodule

/* rtl/oag_geometry.sv */
// ----------------------------------------------------------------------------
// oag_geometry
// Placement check, clipping and row offset product for one source byte,
// registered as an address operation for the final add.
// ----------------------------------------------------------------------------
module oag_geometry #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            in_valid,
    input  oag_pkg::geom_cfg_t              cfg,
    input  oag_pkg::plane_t                 plane,
    input  logic [$clog2(MAX_HEIGHT)-1:0]   row,
    input  logic [$clog2(MAX_WIDTH)-1:0]    col,
    input  logic [oag_pkg::DATA_W-1:0]      data,
    output logic                            valid,
    output oag_pkg::addr_op_t               op
);

    localparam int SW    = oag_pkg::SIZE_W;
    localparam int EXT_W = oag_pkg::SIZE_W + 1;
    localparam int PRD_W = EXT_W + oag_pkg::SIZE_W;

    logic [SW-1:0]    ux, uy, dw, dh, sw, sh;
    logic             rej, luma, in_region;
    logic [EXT_W-1:0] x_end, y_end, row_sum;
    logic [SW-1:0]    row_size, row_count, dw_sel, x_sel;
    logic [PRD_W-1:0] row_prod, size_prod;

    logic             valid_reg;
    oag_pkg::addr_op_t op_reg, op_next;

    always_comb
    begin
        dw = cfg.dest_width;
        dh = cfg.dest_height;
        sw = cfg.src_width;
        sh = cfg.src_height;
        ux = cfg.pos_x;
        uy = cfg.pos_y;
        rej = cfg.pos_x[oag_pkg::POS_W-1] | cfg.pos_y[oag_pkg::POS_W-1]
            | (ux > dw) | (uy > dh);
        x_end     = {1'b0, ux} + {1'b0, sw};
        y_end     = {1'b0, uy} + {1'b0, sh};
        row_size  = (x_end > {1'b0, dw}) ? (dw - ux) : sw;
        row_count = (y_end > {1'b0, dh}) ? (dh - uy) : sh;
        luma      = (plane == oag_pkg::PLANE_Y);
        if (luma)
        begin
            in_region = (EXT_W'(row) < {1'b0, row_count}) && (SW'(col) < row_size);
        end
        else
        begin
            in_region = (EXT_W'({row, 1'b0}) < {1'b0, row_count})
                     && (SW'(col) < (row_size >> 1));
        end
        row_sum   = luma ? ({1'b0, uy} + EXT_W'(row)) : ({2'b0, uy[SW-1:1]} + EXT_W'(row));
        dw_sel    = luma ? dw : (dw >> 1);
        x_sel     = luma ? ux : (ux >> 1);
        row_prod  = PRD_W'(row_sum) * PRD_W'(dw_sel);
        size_prod = PRD_W'(dw) * PRD_W'(dh);

        op_next.wr         = !rej && (plane != oag_pkg::PLANE_DONE) && in_region;
        op_next.rej        = rej;
        op_next.plane      = plane;
        op_next.data       = data;
        op_next.row_base   = row_prod[oag_pkg::ADDR_W-1:0];
        op_next.luma_size  = size_prod[oag_pkg::ADDR_W-1:0];
        op_next.col_offset = oag_pkg::ADDR_W'(x_sel) + oag_pkg::ADDR_W'(col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg <= op_next;
        end
    end

    assign valid = valid_reg;
    assign op    = op_reg;

endmodule

/* rtl/oag_address.sv */
// ----------------------------------------------------------------------------
// oag_address
// Final address sum (plane base, row base, column) and the output register.
// ----------------------------------------------------------------------------
module oag_address (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            in_valid,
    input  oag_pkg::addr_op_t               op,
    output logic                            valid,
    output logic                            write_enable,
    output logic [oag_pkg::ADDR_W-1:0]      dest_address,
    output logic [oag_pkg::DATA_W-1:0]      write_data,
    output logic                            rejected
);

    logic [oag_pkg::ADDR_W-1:0] plane_base, addr_next;
    logic                       valid_reg;
    logic                       we_reg, rej_reg;
    logic [oag_pkg::ADDR_W-1:0] addr_reg;
    logic [oag_pkg::DATA_W-1:0] data_reg;

    always_comb
    begin
        case (op.plane)
            oag_pkg::PLANE_CB: plane_base = op.luma_size;
            oag_pkg::PLANE_CR: plane_base = op.luma_size + (op.luma_size >> 2);
            default:           plane_base = '0;
        endcase
        addr_next = op.wr ? (plane_base + op.row_base + op.col_offset) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            we_reg   <= op.wr;
            rej_reg  <= op.rej;
            addr_reg <= addr_next;
            data_reg <= op.data;
        end
    end

    assign valid        = valid_reg;
    assign write_enable = we_reg;
    assign dest_address = addr_reg;
    assign write_data   = data_reg;
    assign rejected     = rej_reg;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// yuv420_overlay_address_gen testbench
// Streams planar yuv 4:2:0 overlay frames into the address generator under
// many placements and frame geometries, including clipped, edge and rejected
// placements, and out of range sizes. Each result beat is checked field by
// field against fixed values or an in-bench model of the counters and the
// clip arithmetic. Random gaps on the input side and random output stalls.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 4096;

    typedef struct packed {
        logic                       wr;
        logic [oag_pkg::ADDR_W-1:0] addr;
        logic [oag_pkg::DATA_W-1:0] data;
        logic                       rej;
    } wr_cmd_t;

    typedef struct packed {
        logic                            cfg;
        logic [oag_pkg::CFG_INDEX_W-1:0] idx;
        logic [oag_pkg::CFG_DATA_W-1:0]  val;
        logic                            fs;
        logic [oag_pkg::DATA_W-1:0]      b;
        logic                            typed;
        wr_cmd_t                         want;
    } step_t;

    localparam logic [oag_pkg::CFG_INDEX_W-1:0] SIZE_REGS [4] =
        '{oag_pkg::REG_DEST_WIDTH, oag_pkg::REG_DEST_HEIGHT,
          oag_pkg::REG_SRC_WIDTH, oag_pkg::REG_SRC_HEIGHT};
    localparam logic [oag_pkg::CFG_INDEX_W-1:0] POS_REGS [2] =
        '{oag_pkg::REG_POS_X, oag_pkg::REG_POS_Y};
    localparam logic [oag_pkg::CFG_DATA_W-1:0] SIZE_EDGES [8] =
        '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4095, 14'd4096, 14'd4097, 14'h3FFF};
    localparam logic [oag_pkg::CFG_DATA_W-1:0] POS_EDGES [4] =
        '{14'h2000, 14'h1000, 14'h1FFF, 14'h3FFF};

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [oag_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [oag_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic                            frame_start;
    logic [oag_pkg::DATA_W-1:0]      source_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic                            write_enable;
    logic [oag_pkg::ADDR_W-1:0]      dest_address;
    logic [oag_pkg::DATA_W-1:0]      write_data;
    logic                            rejected;

    // model copy of the geometry and the position counters
    logic [oag_pkg::CFG_SIZE_W-1:0] m_dest_w, m_dest_h, m_src_w, m_src_h;
    logic [oag_pkg::POS_W-1:0]      m_pos_x, m_pos_y;
    oag_pkg::plane_t                cur_plane;
    logic [12:0]                    cur_row, cur_col;

    wr_cmd_t pending_writes [$];
    int      error_count;

    yuv420_overlay_address_gen u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_start  (frame_start),
        .source_byte  (source_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .dest_address (dest_address),
        .write_data   (write_data),
        .rejected     (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL yuv420_overlay_address_gen");
        $finish;
    end

    function automatic logic [12:0] clamp_even(input logic [12:0] v);
        logic [12:0] t;
        t = v;
        if (t < 13'd2)
        begin
            t = 13'd2;
        end
        if (t > 13'(MAX_DIM))
        begin
            t = 13'(MAX_DIM);
        end
        t[0] = 1'b0;
        return t;
    endfunction

    function automatic wr_cmd_t place_byte(input logic fs,
                                           input logic [oag_pkg::DATA_W-1:0] b);
        wr_cmd_t     c;
        logic [12:0] dw, dh, sw, sh, pw, ph;
        int          px, py;
        int unsigned ux, uy, row_size, row_count, ysize, base;
        logic        hit;
        dw = clamp_even(m_dest_w);
        dh = clamp_even(m_dest_h);
        sw = clamp_even(m_src_w);
        sh = clamp_even(m_src_h);
        px = $signed(m_pos_x);
        py = $signed(m_pos_y);
        c.wr = 1'b0;
        c.addr = '0;
        c.data = b;
        c.rej = (px < 0) || (py < 0) || (px > int'(dw)) || (py > int'(dh));
        if (fs)
        begin
            cur_plane = oag_pkg::PLANE_Y;
            cur_row = '0;
            cur_col = '0;
        end
        pw = (cur_plane == oag_pkg::PLANE_Y) ? sw : sw >> 1;
        ph = (cur_plane == oag_pkg::PLANE_Y) ? sh : sh >> 1;
        if (!c.rej && cur_plane != oag_pkg::PLANE_DONE)
        begin
            ux = px;
            uy = py;
            row_size = (ux + sw > dw) ? dw - ux : sw;
            row_count = (uy + sh > dh) ? dh - uy : sh;
            ysize = 32'(dw) * 32'(dh);
            if (cur_plane == oag_pkg::PLANE_Y)
            begin
                base = (uy + cur_row) * dw + ux;
                hit = (cur_row < row_count) && (cur_col < row_size);
            end
            else
            begin
                base = ysize + ((cur_plane == oag_pkg::PLANE_CR) ? ysize / 4 : 32'd0)
                     + (uy / 2 + cur_row) * (dw / 2) + ux / 2;
                hit = (2 * cur_row < row_count) && (cur_col < row_size / 2);
            end
            if (hit)
            begin
                c.wr = 1'b1;
                c.addr = oag_pkg::ADDR_W'(base + cur_col);
            end
        end
        if (cur_plane != oag_pkg::PLANE_DONE)
        begin
            cur_col = cur_col + 13'd1;
            if (cur_col >= pw)
            begin
                cur_col = '0;
                cur_row = cur_row + 13'd1;
                if (cur_row >= ph)
                begin
                    cur_row = '0;
                    cur_plane = oag_pkg::plane_t'(cur_plane + 2'd1);
                end
            end
        end
        return c;
    endfunction

    function automatic step_t cfg_row(input logic [oag_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [oag_pkg::CFG_DATA_W-1:0] val);
        step_t s;
        s = '0;
        s.cfg = 1'b1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic step_t beat_row(input logic fs,
                                       input logic [oag_pkg::DATA_W-1:0] b);
        step_t s;
        s = '0;
        s.fs = fs;
        s.b = b;
        return s;
    endfunction

    function automatic step_t fixed_row(input logic fs,
                                        input logic [oag_pkg::DATA_W-1:0] b,
                                        input logic wr,
                                        input logic [oag_pkg::ADDR_W-1:0] addr,
                                        input logic rej);
        step_t s;
        s = beat_row(fs, b);
        s.typed = 1'b1;
        s.want.wr = wr;
        s.want.addr = addr;
        s.want.data = b;
        s.want.rej = rej;
        return s;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic write_reg(input logic [oag_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [oag_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            oag_pkg::REG_DEST_WIDTH:  m_dest_w = val[oag_pkg::CFG_SIZE_W-1:0];
            oag_pkg::REG_DEST_HEIGHT: m_dest_h = val[oag_pkg::CFG_SIZE_W-1:0];
            oag_pkg::REG_SRC_WIDTH:   m_src_w = val[oag_pkg::CFG_SIZE_W-1:0];
            oag_pkg::REG_SRC_HEIGHT:  m_src_h = val[oag_pkg::CFG_SIZE_W-1:0];
            oag_pkg::REG_POS_X:       m_pos_x = val;
            oag_pkg::REG_POS_Y:       m_pos_y = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(input bit busy);
        int unsigned n;
        n = 0;
        if (!busy)
        begin
            case ($urandom_range(0, 19))
                0: n = $urandom_range(8, 40);
                1, 2, 3, 4, 5: n = $urandom_range(1, 3);
                default: n = 0;
            endcase
        end
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_beat(input logic fs, input logic [oag_pkg::DATA_W-1:0] b,
                             input logic typed, input wr_cmd_t given);
        wr_cmd_t c;
        in_valid <= 1'b1;
        frame_start <= fs;
        source_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        c = place_byte(fs, b);
        pending_writes.push_back(typed ? given : c);
        @(negedge clk);
    endtask

    // output side stall pattern
    initial
    begin
        int unsigned hold_n;
        logic        level;
        out_stall = 1'b0;
        hold_n = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_n == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        level = 1'b0;
                        hold_n = $urandom_range(50, 150);
                    end
                    2:
                    begin
                        level = 1'b1;
                        hold_n = $urandom_range(10, 40);
                    end
                    3, 4, 5, 6, 7, 8, 9:
                    begin
                        level = 1'b1;
                        hold_n = $urandom_range(1, 3);
                    end
                    default:
                    begin
                        level = 1'b0;
                        hold_n = $urandom_range(1, 30);
                    end
                endcase
            end
            hold_n--;
            out_stall <= level;
        end
    end

    always @(posedge clk)
    begin
        wr_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                note_error("result beat with nothing pending");
            end
            else
            begin
                want = pending_writes.pop_front();
                if (write_enable !== want.wr)
                begin
                    note_error($sformatf("write_enable got %b want %b",
                                         write_enable, want.wr));
                end
                if (dest_address !== want.addr)
                begin
                    note_error($sformatf("dest_address got %0d want %0d",
                                         dest_address, want.addr));
                end
                if (write_data !== want.data)
                begin
                    note_error($sformatf("write_data got %02h want %02h",
                                         write_data, want.data));
                end
                if (rejected !== want.rej)
                begin
                    note_error($sformatf("rejected got %b want %b", rejected, want.rej));
                end
            end
        end
    end

    initial
    begin
        step_t                          directed [$];
        step_t                          row;
        int unsigned                    sent, frames, nbytes, lim;
        logic [oag_pkg::CFG_DATA_W-1:0] v;
        bit                             busy, start_it;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = oag_pkg::REG_DEST_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        frame_start = 1'b0;
        source_byte = '0;
        error_count = 0;
        m_dest_w = oag_pkg::DEST_WIDTH_RST;
        m_dest_h = oag_pkg::DEST_HEIGHT_RST;
        m_src_w = oag_pkg::SRC_WIDTH_RST;
        m_src_h = oag_pkg::SRC_HEIGHT_RST;
        m_pos_x = '0;
        m_pos_y = '0;
        cur_plane = oag_pkg::PLANE_Y;
        cur_row = '0;
        cur_col = '0;

        // default geometry straight after reset
        directed.push_back(fixed_row(1'b1, 8'h00, 1'b1, 25'd0, 1'b0));
        directed.push_back(fixed_row(1'b0, 8'hFF, 1'b1, 25'd1, 1'b0));
        directed.push_back(beat_row(1'b0, 8'h5A));
        // odd and zero source sizes, clipped at the right edge
        directed.push_back(cfg_row(oag_pkg::REG_DEST_WIDTH, 14'd8));
        directed.push_back(cfg_row(oag_pkg::REG_DEST_HEIGHT, 14'd4));
        directed.push_back(cfg_row(oag_pkg::REG_SRC_WIDTH, 14'd3));
        directed.push_back(cfg_row(oag_pkg::REG_SRC_HEIGHT, 14'd0));
        directed.push_back(cfg_row(oag_pkg::REG_POS_X, 14'd7));
        directed.push_back(cfg_row(oag_pkg::REG_POS_Y, 14'd1));
        directed.push_back(beat_row(1'b1, 8'h11));
        directed.push_back(beat_row(1'b0, 8'h22));
        directed.push_back(beat_row(1'b0, 8'h33));
        directed.push_back(beat_row(1'b0, 8'h44));
        directed.push_back(beat_row(1'b0, 8'h55));
        directed.push_back(beat_row(1'b0, 8'h66));
        directed.push_back(beat_row(1'b0, 8'h77));
        // negative placement
        directed.push_back(cfg_row(oag_pkg::REG_POS_X, 14'h2000));
        directed.push_back(fixed_row(1'b1, 8'hA5, 1'b0, 25'd0, 1'b1));
        directed.push_back(fixed_row(1'b0, 8'h3C, 1'b0, 25'd0, 1'b1));
        // placement on the right edge, then one past it
        directed.push_back(cfg_row(oag_pkg::REG_POS_X, 14'd8));
        directed.push_back(beat_row(1'b1, 8'h81));
        directed.push_back(beat_row(1'b0, 8'h18));
        directed.push_back(cfg_row(oag_pkg::REG_POS_X, 14'd9));
        directed.push_back(fixed_row(1'b1, 8'h0F, 1'b0, 25'd0, 1'b1));
        // vertical placement past, on and negative
        directed.push_back(cfg_row(oag_pkg::REG_POS_X, 14'd0));
        directed.push_back(cfg_row(oag_pkg::REG_POS_Y, 14'd5));
        directed.push_back(fixed_row(1'b1, 8'hF0, 1'b0, 25'd0, 1'b1));
        directed.push_back(cfg_row(oag_pkg::REG_POS_Y, 14'd4));
        directed.push_back(beat_row(1'b1, 8'h99));
        directed.push_back(cfg_row(oag_pkg::REG_POS_Y, 14'h3FFF));
        directed.push_back(fixed_row(1'b1, 8'h66, 1'b0, 25'd0, 1'b1));
        directed.push_back(cfg_row(oag_pkg::REG_POS_Y, 14'h1FFF));
        directed.push_back(fixed_row(1'b1, 8'hC3, 1'b0, 25'd0, 1'b1));
        // saturated destination, overlay in the far corner
        directed.push_back(cfg_row(oag_pkg::REG_DEST_WIDTH, 14'h1FFF));
        directed.push_back(cfg_row(oag_pkg::REG_DEST_HEIGHT, 14'h3FFF));
        directed.push_back(cfg_row(oag_pkg::REG_SRC_WIDTH, 14'd2));
        directed.push_back(cfg_row(oag_pkg::REG_SRC_HEIGHT, 14'd2));
        directed.push_back(cfg_row(oag_pkg::REG_POS_X, 14'd4094));
        directed.push_back(cfg_row(oag_pkg::REG_POS_Y, 14'd4094));
        directed.push_back(beat_row(1'b1, 8'h01));
        directed.push_back(beat_row(1'b0, 8'h80));
        directed.push_back(beat_row(1'b0, 8'h7F));
        directed.push_back(beat_row(1'b0, 8'hFE));
        directed.push_back(beat_row(1'b0, 8'hAA));
        directed.push_back(beat_row(1'b0, 8'h55));
        directed.push_back(beat_row(1'b0, 8'hEE));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            if (row.cfg)
            begin
                wait_drain();
                write_reg(row.idx, row.val);
            end
            else
            begin
                idle_gap(1'b0);
                send_beat(row.fs, row.b, row.typed, row.want);
            end
        end

        sent = 0;
        while (sent < 800)
        begin
            wait_drain();
            // sizes first so the placement can follow the new destination
            foreach (SIZE_REGS[ri])
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0: v = oag_pkg::CFG_DATA_W'($urandom_range(0, 16383));
                        1: v = SIZE_EDGES[$urandom_range(0, 7)];
                        default:
                        begin
                            if (SIZE_REGS[ri] == oag_pkg::REG_DEST_WIDTH
                                || SIZE_REGS[ri] == oag_pkg::REG_DEST_HEIGHT)
                            begin
                                v = oag_pkg::CFG_DATA_W'($urandom_range(2, 64));
                            end
                            else
                            begin
                                v = oag_pkg::CFG_DATA_W'($urandom_range(2, 12));
                            end
                        end
                    endcase
                    write_reg(SIZE_REGS[ri], v);
                end
            end
            foreach (POS_REGS[pi])
            begin
                if (POS_REGS[pi] == oag_pkg::REG_POS_X)
                begin
                    lim = clamp_even(m_dest_w);
                end
                else
                begin
                    lim = clamp_even(m_dest_h);
                end
                case ($urandom_range(0, 39))
                    0: v = oag_pkg::CFG_DATA_W'($urandom_range(0, 16383));
                    1: v = oag_pkg::CFG_DATA_W'(lim + 1);
                    2: v = POS_EDGES[$urandom_range(0, 3)];
                    3, 4: v = oag_pkg::CFG_DATA_W'(lim);
                    default: v = oag_pkg::CFG_DATA_W'($urandom_range(0, lim));
                endcase
                write_reg(POS_REGS[pi], v);
            end

            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    wait_drain();
                end
                busy = ($urandom_range(0, 3) == 0);
                start_it = ($urandom_range(0, 15) != 0);
                nbytes = 32'(clamp_even(m_src_w)) * 32'(clamp_even(m_src_h)) * 3 / 2;
                if (nbytes > 300 || $urandom_range(0, 7) == 0)
                begin
                    nbytes = $urandom_range(1, (nbytes > 60) ? 60 : nbytes);
                end
                nbytes += $urandom_range(0, 2);
                for (int k = 0; k < nbytes; k++)
                begin
                    idle_gap(busy);
                    send_beat((k == 0 && start_it) || ($urandom_range(0, 99) == 0),
                              oag_pkg::DATA_W'($urandom), 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (pending_writes.size() != 0)
        begin
            note_error($sformatf("%0d results never arrived", pending_writes.size()));
        end
        if (error_count == 0)
        begin
            $display("PASS yuv420_overlay_address_gen");
        end
        else
        begin
            $display("FAIL yuv420_overlay_address_gen");
        end
        $finish;
    end

endmodule
